// ----- hdl/clsbu_pkg.sv -----
// Shared constants, codes and types for the character LCD shadow buffer updater.
// Used by clsbu_ctrl, clsbu_dp and the top level; depends on nothing else.
package clsbu_pkg;

    // Frame geometry
    localparam int COLS   = 16;
    localparam int ROWS   = 2;
    localparam int CELLS  = ROWS * COLS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Field widths fixed by the interface
    localparam int CNT_W  = 5;   // active_columns, pos_x magnitude, msg_length
    localparam int RCNT_W = 2;   // active_rows
    localparam int CHAR_W = 8;
    localparam int OCOL_W = 5;
    localparam int OROW_W = 1;
    localparam int KIND_W = 2;

    // Column modulo: restoring divide, one quotient bit per cycle
    localparam int MOD_STEPS = CNT_W;
    localparam int STEP_W    = $clog2(MOD_STEPS);
    localparam int DIV_W     = CNT_W + MOD_STEPS - 1;

    localparam logic [CHAR_W-1:0] SPACE = 8'h20;

    // Command codes (func field)
    localparam logic [2:0] FUNC_SET_CURSOR = 3'd0;
    localparam logic [2:0] FUNC_WRITE_CHAR = 3'd1;
    localparam logic [2:0] FUNC_CLEAR_ALL  = 3'd2;
    localparam logic [2:0] FUNC_RENDER     = 3'd3;
    localparam logic [2:0] FUNC_CENTRE     = 3'd4;
    localparam logic [2:0] FUNC_CLEAR_ROW  = 3'd5;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] REG_ACTIVE_COLUMNS = 1'b0;
    localparam logic [0:0] REG_ACTIVE_ROWS    = 1'b1;

    // Controller to datapath commands
    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_NONE      = 3'd0;
    localparam cmd_t CMD_LOAD      = 3'd1;
    localparam cmd_t CMD_MOD_STEP  = 3'd2;
    localparam cmd_t CMD_SKIP      = 3'd3;
    localparam cmd_t CMD_EMIT_MOVE = 3'd4;
    localparam cmd_t CMD_EMIT_CHAR = 3'd5;
    localparam cmd_t CMD_EMIT_DONE = 3'd6;

    // Datapath to controller status
    typedef struct packed {
        logic render;       // incoming request is a render
        logic mod_pending;  // incoming request needs the column modulo
        logic mod_end;      // last modulo step
        logic cell_diff;    // current walk cell differs from shown frame
        logic in_run;       // a changed run is open in this row
        logic walk_end;     // current walk cell is the last active cell
        logic out_free;     // output register can take a result this cycle
    } status_t;

endpackage

// ----- hdl/clsbu_ctrl.sv -----
// Controller state machine of the character LCD shadow buffer updater.
// Sequences request load, column modulo steps and the render walk; uses clsbu_pkg.
module clsbu_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  clsbu_pkg::status_t status,
    output clsbu_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_CHAR = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = clsbu_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd = clsbu_pkg::CMD_LOAD;
                    if (status.render)
                        state_next = S_WALK;
                    else if (status.mod_pending)
                        state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd = clsbu_pkg::CMD_MOD_STEP;
                if (status.mod_end)
                    state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (!status.cell_diff)
                begin
                    // unchanged cell: copy and advance, no result
                    cmd = clsbu_pkg::CMD_SKIP;
                    if (status.walk_end)
                        state_next = S_DONE;
                end
                else if (status.out_free)
                begin
                    if (status.in_run)
                    begin
                        cmd = clsbu_pkg::CMD_EMIT_CHAR;
                        if (status.walk_end)
                            state_next = S_DONE;
                    end
                    else
                    begin
                        // open a run: move the display cursor first
                        cmd        = clsbu_pkg::CMD_EMIT_MOVE;
                        state_next = S_CHAR;
                    end
                end
            end
            S_CHAR:
            begin
                if (status.out_free)
                begin
                    cmd        = clsbu_pkg::CMD_EMIT_CHAR;
                    state_next = status.walk_end ? S_DONE : S_WALK;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd        = clsbu_pkg::CMD_EMIT_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hdl/clsbu_dp.sv -----
// Datapath of the character LCD shadow buffer updater: frames, cursor,
// configuration, column modulo unit, render walk and output register; uses clsbu_pkg.
module clsbu_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  clsbu_pkg::cmd_t                      cmd,
    output clsbu_pkg::status_t                   status,
    input  logic                                 cfg_valid,
    input  logic [0:0]                           cfg_index,
    input  logic [clsbu_pkg::CNT_W-1:0]          cfg_data,
    input  logic [2:0]                           func,
    input  logic signed [5:0]                    pos_x,
    input  logic signed [2:0]                    pos_y,
    input  logic [clsbu_pkg::CHAR_W-1:0]         char_code,
    input  logic [clsbu_pkg::CNT_W-1:0]          msg_length,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [clsbu_pkg::KIND_W-1:0]         out_kind,
    output logic [clsbu_pkg::OCOL_W-1:0]         out_col,
    output logic [clsbu_pkg::OROW_W-1:0]         out_row,
    output logic [clsbu_pkg::CHAR_W-1:0]         out_char,
    output logic                                 out_last
);

    // Configuration
    logic [clsbu_pkg::CNT_W-1:0]  act_cols_reg;
    logic [clsbu_pkg::RCNT_W-1:0] act_rows_reg;

    // Frames and cursor
    logic [clsbu_pkg::CHAR_W-1:0] drawn_reg [clsbu_pkg::CELLS];
    logic [clsbu_pkg::CHAR_W-1:0] shown_reg [clsbu_pkg::CELLS];
    logic [clsbu_pkg::COL_W-1:0]  cur_col_reg;
    logic [clsbu_pkg::ROW_W-1:0]  cur_row_reg;

    // Modulo unit and render walk
    logic [clsbu_pkg::CNT_W-1:0]  rem_reg;
    logic [clsbu_pkg::STEP_W-1:0] step_reg;
    logic [clsbu_pkg::COL_W-1:0]  walk_col_reg;
    logic [clsbu_pkg::ROW_W-1:0]  walk_row_reg;
    logic                         run_reg;

    // Output register
    logic                         out_valid_reg;
    logic [clsbu_pkg::KIND_W-1:0] out_kind_reg;
    logic [clsbu_pkg::OCOL_W-1:0] out_col_reg;
    logic [clsbu_pkg::OROW_W-1:0] out_row_reg;
    logic [clsbu_pkg::CHAR_W-1:0] out_char_reg;
    logic                         out_last_reg;

    logic [clsbu_pkg::CNT_W-1:0]  nc;
    logic [clsbu_pkg::RCNT_W-1:0] nr;
    logic [clsbu_pkg::ROW_W-1:0]  in_row;
    logic [clsbu_pkg::COL_W-1:0]  neg_col;
    logic signed [6:0]            neg_sum;
    logic [clsbu_pkg::COL_W-1:0]  centre_col;
    logic [clsbu_pkg::DIV_W-1:0]  div_shift;
    logic [clsbu_pkg::CNT_W-1:0]  rem_new;
    logic [clsbu_pkg::CELL_W-1:0] cur_addr;
    logic [clsbu_pkg::CELL_W-1:0] walk_addr;
    logic [clsbu_pkg::CHAR_W-1:0] walk_drawn;
    logic                         row_last;
    logic                         walk_end;
    logic                         out_load;

    function automatic logic [clsbu_pkg::ROW_W-1:0] map_row
    (
        input logic signed [2:0]            v,
        input logic [clsbu_pkg::RCNT_W-1:0] rows
    );
        logic signed [3:0] t;
        t = $signed({2'b00, rows}) + $signed({v[2], v});
        if (!v[2])
            map_row = (rows == 2'd2) ? clsbu_pkg::ROW_W'(v[0]) : '0;
        else if (t[3])
            map_row = '0;
        else
            map_row = clsbu_pkg::ROW_W'(t[0]);
    endfunction

    // Effective sizes clamped to the storage
    always_comb
    begin
        if (act_cols_reg == '0)
            nc = clsbu_pkg::CNT_W'(1);
        else if (act_cols_reg > clsbu_pkg::CNT_W'(clsbu_pkg::COLS))
            nc = clsbu_pkg::CNT_W'(clsbu_pkg::COLS);
        else
            nc = act_cols_reg;

        if (act_rows_reg == '0)
            nr = clsbu_pkg::RCNT_W'(1);
        else if (act_rows_reg > clsbu_pkg::RCNT_W'(clsbu_pkg::ROWS))
            nr = clsbu_pkg::RCNT_W'(clsbu_pkg::ROWS);
        else
            nr = act_rows_reg;
    end

    assign in_row     = map_row(pos_y, nr);
    assign neg_sum    = $signed({2'b00, nc}) + $signed({pos_x[5], pos_x});
    assign neg_col    = neg_sum[6] ? '0 : clsbu_pkg::COL_W'(neg_sum[clsbu_pkg::CNT_W-1:0]);
    assign centre_col = (msg_length >= nc) ? '0 : clsbu_pkg::COL_W'((nc - msg_length) >> 1);

    // One restoring step of the column modulo
    assign div_shift = clsbu_pkg::DIV_W'(nc) << step_reg;
    assign rem_new   = (clsbu_pkg::DIV_W'(rem_reg) >= div_shift)
                     ? rem_reg - clsbu_pkg::CNT_W'(div_shift) : rem_reg;

    assign cur_addr   = clsbu_pkg::CELL_W'(cur_row_reg) * clsbu_pkg::CELL_W'(clsbu_pkg::COLS)
                      + clsbu_pkg::CELL_W'(cur_col_reg);
    assign walk_addr  = clsbu_pkg::CELL_W'(walk_row_reg) * clsbu_pkg::CELL_W'(clsbu_pkg::COLS)
                      + clsbu_pkg::CELL_W'(walk_col_reg);
    assign walk_drawn = drawn_reg[walk_addr];
    assign row_last   = (clsbu_pkg::CNT_W'(walk_col_reg) == nc - clsbu_pkg::CNT_W'(1));
    assign walk_end   = row_last
                      && (clsbu_pkg::RCNT_W'(walk_row_reg) == nr - clsbu_pkg::RCNT_W'(1));

    assign out_load = (cmd == clsbu_pkg::CMD_EMIT_MOVE) || (cmd == clsbu_pkg::CMD_EMIT_CHAR)
                   || (cmd == clsbu_pkg::CMD_EMIT_DONE);

    always_comb
    begin
        status.render      = (func == clsbu_pkg::FUNC_RENDER);
        status.mod_pending = ((func == clsbu_pkg::FUNC_SET_CURSOR) && !pos_x[5])
                          || (func == clsbu_pkg::FUNC_WRITE_CHAR);
        status.mod_end     = (step_reg == '0);
        status.cell_diff   = (walk_drawn != shown_reg[walk_addr]);
        status.in_run      = run_reg;
        status.walk_end    = walk_end;
        status.out_free    = !out_valid_reg || out_ready;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_cols_reg <= clsbu_pkg::CNT_W'(16);
            act_rows_reg <= clsbu_pkg::RCNT_W'(2);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == clsbu_pkg::REG_ACTIVE_COLUMNS)
                act_cols_reg <= cfg_data;
            else
                act_rows_reg <= cfg_data[clsbu_pkg::RCNT_W-1:0];
        end
    end

    // Frames, cursor, modulo unit and walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < clsbu_pkg::CELLS; i++)
            begin
                drawn_reg[clsbu_pkg::CELL_W'(i)] <= clsbu_pkg::SPACE;
                shown_reg[clsbu_pkg::CELL_W'(i)] <= '0;
            end
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            rem_reg      <= '0;
            step_reg     <= '0;
            walk_col_reg <= '0;
            walk_row_reg <= '0;
            run_reg      <= 1'b0;
        end
        else
        begin
            case (cmd) inside
                clsbu_pkg::CMD_LOAD:
                begin
                    case (func)
                        clsbu_pkg::FUNC_SET_CURSOR:
                        begin
                            cur_row_reg <= in_row;
                            if (pos_x[5])
                                cur_col_reg <= neg_col;
                            else
                            begin
                                rem_reg  <= clsbu_pkg::CNT_W'(pos_x[4:0]);
                                step_reg <= clsbu_pkg::STEP_W'(clsbu_pkg::MOD_STEPS - 1);
                            end
                        end
                        clsbu_pkg::FUNC_WRITE_CHAR:
                        begin
                            drawn_reg[cur_addr] <= char_code;
                            rem_reg  <= clsbu_pkg::CNT_W'(cur_col_reg) + clsbu_pkg::CNT_W'(1);
                            step_reg <= clsbu_pkg::STEP_W'(clsbu_pkg::MOD_STEPS - 1);
                        end
                        clsbu_pkg::FUNC_CLEAR_ALL:
                        begin
                            for (int r = 0; r < clsbu_pkg::ROWS; r++)
                                for (int c = 0; c < clsbu_pkg::COLS; c++)
                                    if ((clsbu_pkg::RCNT_W'(r) < nr)
                                        && (clsbu_pkg::CNT_W'(c) < nc))
                                        drawn_reg[clsbu_pkg::CELL_W'(r * clsbu_pkg::COLS + c)]
                                            <= clsbu_pkg::SPACE;
                        end
                        clsbu_pkg::FUNC_RENDER:
                        begin
                            walk_col_reg <= '0;
                            walk_row_reg <= '0;
                            run_reg      <= 1'b0;
                        end
                        clsbu_pkg::FUNC_CENTRE:
                        begin
                            cur_row_reg <= in_row;
                            cur_col_reg <= centre_col;
                        end
                        clsbu_pkg::FUNC_CLEAR_ROW:
                        begin
                            for (int r = 0; r < clsbu_pkg::ROWS; r++)
                                for (int c = 0; c < clsbu_pkg::COLS; c++)
                                    if ((clsbu_pkg::ROW_W'(r) == in_row)
                                        && (clsbu_pkg::CNT_W'(c) < nc))
                                        drawn_reg[clsbu_pkg::CELL_W'(r * clsbu_pkg::COLS + c)]
                                            <= clsbu_pkg::SPACE;
                            cur_row_reg <= in_row;
                            cur_col_reg <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                clsbu_pkg::CMD_MOD_STEP:
                begin
                    rem_reg  <= rem_new;
                    step_reg <= step_reg - clsbu_pkg::STEP_W'(1);
                    if (step_reg == '0)
                        cur_col_reg <= clsbu_pkg::COL_W'(rem_new);
                end
                clsbu_pkg::CMD_EMIT_MOVE:
                begin
                    run_reg <= 1'b1;
                end
                clsbu_pkg::CMD_SKIP, clsbu_pkg::CMD_EMIT_CHAR:
                begin
                    shown_reg[walk_addr] <= walk_drawn;
                    run_reg <= (cmd == clsbu_pkg::CMD_EMIT_CHAR) && !row_last;
                    if (row_last)
                    begin
                        walk_col_reg <= '0;
                        walk_row_reg <= walk_row_reg + clsbu_pkg::ROW_W'(1);
                    end
                    else
                        walk_col_reg <= walk_col_reg + clsbu_pkg::COL_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register: load a result, drop it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_char_reg <= '0;
            out_last_reg <= 1'b0;
            case (cmd)
                clsbu_pkg::CMD_EMIT_MOVE:
                begin
                    out_kind_reg <= clsbu_pkg::KIND_MOVE;
                    out_col_reg  <= clsbu_pkg::OCOL_W'(walk_col_reg);
                    out_row_reg  <= clsbu_pkg::OROW_W'(walk_row_reg);
                end
                clsbu_pkg::CMD_EMIT_CHAR:
                begin
                    out_kind_reg <= clsbu_pkg::KIND_CHAR;
                    out_char_reg <= walk_drawn;
                end
                default:
                begin
                    out_kind_reg <= clsbu_pkg::KIND_DONE;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- hdl/char_lcd_shadow_buffer_updater_top.sv -----
// Character LCD shadow buffer updater, top level. Set cursor with a non-negative column and
// write char add five modulo steps after the request is accepted.
// Render walks every active cell, emits a cursor move for each changed run and then a done
// result; only one request is handled at a time, and output back-pressure stalls the walk.
// rst_n (async, active low) sets drawn frame to spaces, shown frame to zero, cursor to 0,
// and the column and row counts to 16 and 2.
module char_lcd_shadow_buffer_updater_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // func[2:0], pos_x[8:3], pos_y[11:9], char_code[19:12],
                                   // msg_length[24:20], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_col[4:0], out_row[5], out_char[13:6], zero fill
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    clsbu_pkg::cmd_t    cmd;
    clsbu_pkg::status_t status;

    logic [clsbu_pkg::OCOL_W-1:0] out_col;
    logic [clsbu_pkg::OROW_W-1:0] out_row;
    logic [clsbu_pkg::CHAR_W-1:0] out_char;

    assign cfg_ready = 1'b1;

    clsbu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    clsbu_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .func       (s_tdata[2:0]),
        .pos_x      ($signed(s_tdata[8:3])),
        .pos_y      ($signed(s_tdata[11:9])),
        .char_code  (s_tdata[19:12]),
        .msg_length (s_tdata[24:20]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_kind   (m_tuser),
        .out_col    (out_col),
        .out_row    (out_row),
        .out_char   (out_char),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_char, out_row, out_col};

endmodule

// ----- sim/char_lcd_shadow_buffer_updater_top_tb.sv -----
// Self-checking testbench for char_lcd_shadow_buffer_updater_top: directed table, then random
// command streams under several column/row settings, compared against an in-bench frame model.
// Depends on clsbu_pkg and the top level under hdl/.
module char_lcd_shadow_buffer_updater_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 4000;

    typedef struct packed {
        logic [clsbu_pkg::KIND_W-1:0] kind;
        logic [clsbu_pkg::OCOL_W-1:0] col;
        logic [clsbu_pkg::OROW_W-1:0] row;
        logic [clsbu_pkg::CHAR_W-1:0] ch;
        logic                         last;
    } lcd_res_t;

    typedef struct packed {
        logic       is_cfg;
        logic [0:0] cfg_idx;
        logic [4:0] cfg_val;
        logic [2:0] func;
        logic [5:0] px;
        logic [2:0] py;
        logic [7:0] ch;
        logic [4:0] len;
        logic       typed;
        lcd_res_t   texp;
    } plan_row_t;

    localparam lcd_res_t DONE_ONLY = '{kind: clsbu_pkg::KIND_DONE, col: 5'd0, row: 1'b0,
                                       ch: 8'd0, last: 1'b1};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [31:0] s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [4:0]  cfg_data  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_ready;

    char_lcd_shadow_buffer_updater_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Frame model state
    logic [clsbu_pkg::CHAR_W-1:0] drawn_q [clsbu_pkg::ROWS][clsbu_pkg::COLS];
    logic [clsbu_pkg::CHAR_W-1:0] shown_q [clsbu_pkg::ROWS][clsbu_pkg::COLS];
    int                           cur_col;
    int                           cur_row;
    logic [4:0]                   reg_cols;
    logic [1:0]                   reg_rows;

    lcd_res_t  pending_q [$];
    lcd_res_t  step_out [$];
    plan_row_t plan_q [$];

    int errors     = 0;
    int n_cmds     = 0;
    int n_results  = 0;
    int n_settings = 0;
    int burst_left = 0;

    function automatic int eff_cols();
        int c;
        c = reg_cols;
        if (c < 1) c = 1;
        if (c > clsbu_pkg::COLS) c = clsbu_pkg::COLS;
        return c;
    endfunction

    function automatic int eff_rows();
        int r;
        r = reg_rows;
        if (r < 1) r = 1;
        if (r > clsbu_pkg::ROWS) r = clsbu_pkg::ROWS;
        return r;
    endfunction

    function automatic int fold_coord(int v, int size);
        int t;
        if (v >= 0) return v % size;
        t = size + v;
        if (t < 0) t = 0;
        return t;
    endfunction

    function automatic lcd_res_t mk_res(logic [1:0] kind, logic [4:0] col, logic row,
                                        logic [7:0] ch, logic last);
        lcd_res_t res;
        res.kind = kind;
        res.col  = col;
        res.row  = row;
        res.ch   = ch;
        res.last = last;
        return res;
    endfunction

    function automatic logic [31:0] pack_cmd(logic [2:0] f, logic [5:0] px, logic [2:0] py,
                                             logic [7:0] ch, logic [4:0] len);
        return {7'd0, len, ch, py, px, f};
    endfunction

    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 3) == 0) return clsbu_pkg::SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void frame_reset();
        for (int r = 0; r < clsbu_pkg::ROWS; r++)
            for (int c = 0; c < clsbu_pkg::COLS; c++)
            begin
                drawn_q[r][c] = clsbu_pkg::SPACE;
                shown_q[r][c] = 8'd0;
            end
        cur_col  = 0;
        cur_row  = 0;
        reg_cols = 5'd16;
        reg_rows = 2'd2;
    endfunction

    // Update the frame model for one request and leave its results in step_out
    function automatic void frame_step(logic [31:0] w);
        logic [2:0] f;
        logic [7:0] ch;
        int px, py, len, nc, nr, c, e, x;
        f   = w[2:0];
        px  = $signed(w[8:3]);
        py  = $signed(w[11:9]);
        ch  = w[19:12];
        len = w[24:20];
        nc  = eff_cols();
        nr  = eff_rows();
        step_out.delete();
        case (f)
            clsbu_pkg::FUNC_SET_CURSOR:
            begin
                cur_col = fold_coord(px, nc);
                cur_row = fold_coord(py, nr);
            end
            clsbu_pkg::FUNC_WRITE_CHAR:
            begin
                drawn_q[cur_row][cur_col] = ch;
                cur_col = (cur_col + 1) % nc;
            end
            clsbu_pkg::FUNC_CLEAR_ALL:
            begin
                for (int r = 0; r < nr; r++)
                    for (int k = 0; k < nc; k++)
                        drawn_q[r][k] = clsbu_pkg::SPACE;
            end
            clsbu_pkg::FUNC_RENDER:
            begin
                for (int r = 0; r < nr; r++)
                begin
                    c = 0;
                    while (c < nc)
                    begin
                        if (drawn_q[r][c] == shown_q[r][c])
                            c++;
                        else
                        begin
                            e = c + 1;
                            while (e < nc && drawn_q[r][e] != shown_q[r][e]) e++;
                            step_out.push_back(mk_res(clsbu_pkg::KIND_MOVE, 5'(c), 1'(r),
                                                      8'd0, 1'b0));
                            for (; c < e; c++)
                                step_out.push_back(mk_res(clsbu_pkg::KIND_CHAR, 5'd0, 1'b0,
                                                          drawn_q[r][c], 1'b0));
                        end
                    end
                end
                for (int r = 0; r < nr; r++)
                    for (int k = 0; k < nc; k++)
                        shown_q[r][k] = drawn_q[r][k];
                step_out.push_back(DONE_ONLY);
            end
            clsbu_pkg::FUNC_CENTRE:
            begin
                x = (len >= nc) ? 0 : (nc - len) / 2;
                cur_col = fold_coord(x, nc);
                cur_row = fold_coord(py, nr);
            end
            clsbu_pkg::FUNC_CLEAR_ROW:
            begin
                cur_row = fold_coord(py, nr);
                for (int k = 0; k < nc; k++)
                    drawn_q[cur_row][k] = clsbu_pkg::SPACE;
                cur_col = 0;
            end
            default: ;
        endcase
    endfunction

    // Offer one request; the sender runs in bursts with random gaps in between
    task automatic send_cmd(input logic [31:0] w, input logic typed, input lcd_res_t texp);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_cmds++;
        frame_step(w);
        if (typed)
            pending_q.push_back(texp);
        else
            foreach (step_out[k]) pending_q.push_back(step_out[k]);
    endtask

    // Drop valid, wait for every pending result, then let the block settle
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [0:0] idx, input logic [4:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == clsbu_pkg::REG_ACTIVE_COLUMNS)
            reg_cols = val;
        else
            reg_rows = val[1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void add_cmd(logic [2:0] f, int px, int py, int ch, int len);
        plan_row_t p;
        p = '0;
        p.func = f;
        p.px   = 6'(px);
        p.py   = 3'(py);
        p.ch   = 8'(ch);
        p.len  = 5'(len);
        plan_q.push_back(p);
    endfunction

    function automatic void add_quiet_render();
        plan_row_t p;
        p = '0;
        p.func  = clsbu_pkg::FUNC_RENDER;
        p.typed = 1'b1;
        p.texp  = DONE_ONLY;
        plan_q.push_back(p);
    endfunction

    function automatic void add_cfg(logic [0:0] idx, int val);
        plan_row_t p;
        p = '0;
        p.is_cfg  = 1'b1;
        p.cfg_idx = idx;
        p.cfg_val = 5'(val);
        plan_q.push_back(p);
    endfunction

    task automatic run_setting(input int cols, input int rows, input int n_items);
        int sent, pick, k;
        settle_idle();
        cfg_write(clsbu_pkg::REG_ACTIVE_COLUMNS, 5'(cols));
        cfg_write(clsbu_pkg::REG_ACTIVE_ROWS, 5'(rows));
        n_settings++;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // place the cursor, write a message, render it half the time
                if ($urandom_range(0, 2) == 0)
                    send_cmd(pack_cmd(clsbu_pkg::FUNC_CENTRE, 6'($urandom), 3'($urandom),
                                      8'($urandom), 5'($urandom_range(0, eff_cols() + 2))),
                             1'b0, '0);
                else
                    send_cmd(pack_cmd(clsbu_pkg::FUNC_SET_CURSOR, 6'($urandom),
                                      3'($urandom), 8'($urandom), 5'($urandom)),
                             1'b0, '0);
                sent++;
                k = $urandom_range(1, eff_cols() + 2);
                repeat (k)
                begin
                    send_cmd(pack_cmd(clsbu_pkg::FUNC_WRITE_CHAR, 6'($urandom),
                                      3'($urandom), rand_char(), 5'($urandom)),
                             1'b0, '0);
                    sent++;
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    send_cmd(pack_cmd(clsbu_pkg::FUNC_RENDER, 6'($urandom), 3'($urandom),
                                      8'($urandom), 5'($urandom)),
                             1'b0, '0);
                    sent++;
                end
            end
            else if (pick < 65)
            begin
                send_cmd(pack_cmd(clsbu_pkg::FUNC_CLEAR_ROW, 6'($urandom), 3'($urandom),
                                  8'($urandom), 5'($urandom)),
                         1'b0, '0);
                sent++;
            end
            else if (pick < 70)
            begin
                send_cmd(pack_cmd(clsbu_pkg::FUNC_CLEAR_ALL, 6'($urandom), 3'($urandom),
                                  8'($urandom), 5'($urandom)),
                         1'b0, '0);
                sent++;
            end
            else if (pick < 82)
            begin
                send_cmd(pack_cmd(clsbu_pkg::FUNC_RENDER, 6'($urandom), 3'($urandom),
                                  8'($urandom), 5'($urandom)),
                         1'b0, '0);
                sent++;
            end
            else
            begin
                // noise: any code, spare ones included, with any field content
                send_cmd(pack_cmd(3'($urandom), 6'($urandom), 3'($urandom), 8'($urandom),
                                  5'($urandom)),
                         1'b0, '0);
                sent++;
            end
        end
    endtask

    // Receiver back-pressure: switch at random between stall patterns
    int rdy_mode   = 0;
    int mode_left  = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            rdy_mode  = $urandom_range(0, 3);
            mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
                end
            end
            default: m_tready <= (mode_left % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        lcd_res_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = mk_res(m_tuser, m_tdata[4:0], m_tdata[5], m_tdata[13:6], m_tlast);
            n_results++;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind %0d col %0d row %0d char %02h last %0d",
                         $time, got.kind, got.col, got.row, got.ch, got.last);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.kind !== want.kind)
                begin
                    errors++;
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                end
                if (got.col !== want.col)
                begin
                    errors++;
                    $display("%0t: out_col expected %0d actual %0d", $time, want.col, got.col);
                end
                if (got.row !== want.row)
                begin
                    errors++;
                    $display("%0t: out_row expected %0d actual %0d", $time, want.row, got.row);
                end
                if (got.ch !== want.ch)
                begin
                    errors++;
                    $display("%0t: out_char expected %02h actual %02h", $time, want.ch, got.ch);
                end
                if (got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results still pending",
                 $time, IDLE_LIMIT, pending_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t p;
        frame_reset();

        // first render paints everything, a second one finds nothing to send
        add_cmd(clsbu_pkg::FUNC_RENDER, 0, 0, 0, 0);
        add_quiet_render();
        add_cmd(clsbu_pkg::FUNC_SET_CURSOR, 31, 3, 0, 0);
        add_cmd(clsbu_pkg::FUNC_WRITE_CHAR, 0, 0, 255, 0);
        add_cmd(clsbu_pkg::FUNC_SET_CURSOR, -32, -4, 0, 0);
        add_cmd(clsbu_pkg::FUNC_WRITE_CHAR, 0, 0, 8'h41, 0);
        add_cmd(clsbu_pkg::FUNC_SET_CURSOR, -1, -1, 0, 0);
        add_cmd(clsbu_pkg::FUNC_WRITE_CHAR, 0, 0, 0, 0);
        add_cmd(clsbu_pkg::FUNC_CENTRE, 0, 0, 0, 0);
        add_cmd(clsbu_pkg::FUNC_WRITE_CHAR, 0, 0, 8'h7f, 0);
        add_cmd(clsbu_pkg::FUNC_CENTRE, 0, 1, 0, 20);
        add_cmd(clsbu_pkg::FUNC_CENTRE, 0, -2, 0, 31);
        add_cmd(clsbu_pkg::FUNC_WRITE_CHAR, 0, 0, 8'h42, 0);
        add_cmd(FUNC_SPARE_6, 31, 3, 255, 31);
        add_cmd(FUNC_SPARE_7, -32, -4, 0, 0);
        add_cmd(clsbu_pkg::FUNC_RENDER, 0, 0, 0, 0);
        add_cmd(clsbu_pkg::FUNC_CLEAR_ROW, 0, -1, 0, 0);
        add_cmd(clsbu_pkg::FUNC_WRITE_CHAR, 0, 0, 8'h43, 0);
        add_cmd(clsbu_pkg::FUNC_RENDER, 0, 0, 0, 0);
        add_cmd(clsbu_pkg::FUNC_CLEAR_ALL, 0, 0, 0, 0);
        add_cmd(clsbu_pkg::FUNC_RENDER, 0, 0, 0, 0);
        add_quiet_render();
        // cursor left outside the area after it shrinks
        add_cmd(clsbu_pkg::FUNC_SET_CURSOR, 15, 1, 0, 0);
        add_cfg(clsbu_pkg::REG_ACTIVE_COLUMNS, 4);
        add_cfg(clsbu_pkg::REG_ACTIVE_ROWS, 1);
        add_cmd(clsbu_pkg::FUNC_WRITE_CHAR, 0, 0, 8'h5a, 0);
        add_cmd(clsbu_pkg::FUNC_WRITE_CHAR, 0, 0, 8'h5b, 0);
        add_cmd(clsbu_pkg::FUNC_RENDER, 0, 0, 0, 0);
        add_cfg(clsbu_pkg::REG_ACTIVE_COLUMNS, 16);
        add_cfg(clsbu_pkg::REG_ACTIVE_ROWS, 2);
        add_cmd(clsbu_pkg::FUNC_RENDER, 0, 0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            p = plan_q[i];
            if (p.is_cfg)
            begin
                settle_idle();
                cfg_write(p.cfg_idx, p.cfg_val);
            end
            else
                send_cmd(pack_cmd(p.func, p.px, p.py, p.ch, p.len), p.typed, p.texp);
        end

        run_setting(1, 1, 34);
        run_setting(31, 3, 34);
        run_setting(20, 0, 34);
        run_setting(8, 2, 34);
        run_setting(0, 2, 34);
        run_setting($urandom_range(1, 16), $urandom_range(0, 3), 34);
        run_setting(5, 1, 34);
        run_setting(16, 2, 34);

        settle_idle();
        $display("Sent %0d commands and compared %0d results over %0d random geometry settings",
                 n_cmds, n_results, n_settings);
        $display("plus a directed pass over coordinate extremes, clears and a shrunken area");
        if (errors == 0 && pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/clsbu_pkg.sv
hdl/clsbu_ctrl.sv
hdl/clsbu_dp.sv
hdl/char_lcd_shadow_buffer_updater_top.sv
sim/char_lcd_shadow_buffer_updater_top_tb.sv
